@@ sv/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/ilt_pkg.sv @@
`timescale 1ns / 1ps

package ilt_pkg;

  localparam int DATA_W = 32;

  // Item opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_VALID    = 2'd0;
  localparam logic [1:0] ST_RANGE    = 2'd1;
  localparam logic [1:0] ST_INVERTED = 2'd2;

  // Register index, decoded from paddr[2]
  localparam logic REG_ROW_COUNT = 1'b0;

  typedef struct packed {
    logic signed [DATA_W-1:0] energy;
    logic signed [DATA_W-1:0] low;
    logic signed [DATA_W-1:0] high;
  } row_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_LO,
    S_RD_HI,
    S_RANGE,
    S_PROBE,
    S_CMP,
    S_SEL,
    S_DIV_LO,
    S_DIV_HI,
    S_OUT
  } state_t;

  typedef struct packed {
    logic accept_wr;
    logic accept_q;
    logic rd_first;
    logic cap_l_rd_u;
    logic cap_u;
    logic set_oor;
    logic probe_rd;
    logic u_to_l;
    logic cmp_upd;
    logic start_mdu;
    logic mdu_hi;
    logic cap_lo;
    logic cap_hi;
    logic set_direct;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic op_query;
    logic n_zero;
    logic out_range;
    logic l_lt_u;
    logic e_eq_l;
    logic cmp_break;
    logic do_interp;
    logic mdu_done;
  } sts_t;

  function automatic logic signed [DATA_W:0] sx(input logic signed [DATA_W-1:0] v);
    sx = {v[DATA_W-1], v};
  endfunction

endpackage

@@ sv/ilt_mdu.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

// floor(a * b / d) for b <= d, d > 0: a multiply step, then one quotient
// bit per cycle by restoring division.
module ilt_mdu
  import ilt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DATA_W-1:0] a,
  input  logic [DATA_W-1:0] b,
  input  logic [DATA_W-1:0] d,
  output logic              done,
  output logic [DATA_W-1:0] q
);

  localparam int CNT_W = $clog2(DATA_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_W - 1);

  logic              busy_r, busy_nxt;
  logic              mul_r, mul_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DATA_W-1:0] a_r, b_r, d_r;
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] quo_r, quo_nxt;
  logic [2*DATA_W-1:0] prod;
  logic [DATA_W:0]     trial;
  logic [DATA_W:0]     diff;
  logic                ge;

  assign prod  = a_r * b_r;
  assign trial = {rem_r, quo_r[DATA_W-1]};
  assign diff  = trial - {1'b0, d_r};
  assign ge    = (trial >= {1'b0, d_r});

  always_comb begin
    busy_nxt = busy_r;
    mul_nxt  = mul_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      mul_nxt  = 1'b1;
    end else if (busy_r && mul_r) begin
      // high half is below d, so it seeds the remainder directly
      rem_nxt = prod[2*DATA_W-1:DATA_W];
      quo_nxt = prod[DATA_W-1:0];
      mul_nxt = 1'b0;
      cnt_nxt = '0;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      quo_nxt = {quo_r[DATA_W-2:0], ge};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      mul_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      mul_r  <= mul_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
      d_r <= d;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign q    = quo_r;

  `ASSERT_IMPLIES(a_start_when_free, start, !busy_r, "mdu started while busy")

endmodule

@@ sv/ilt_dp.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ilt_dp
  import ilt_pkg::*;
#(
  parameter int MAX_ROWS = 256
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cmd_t                     cmd,
  output sts_t                     sts,
  input  logic [$clog2(MAX_ROWS+1)-1:0] n,
  input  logic                     in_op,
  input  logic [7:0]               in_row_index,
  input  logic signed [DATA_W-1:0] in_energy_in,
  input  logic signed [DATA_W-1:0] in_low_in,
  input  logic signed [DATA_W-1:0] in_high_in,
  output logic [1:0]               out_status,
  output logic signed [DATA_W-1:0] out_energy_out,
  output logic signed [DATA_W-1:0] out_low_out,
  output logic signed [DATA_W-1:0] out_high_out
);

  localparam int IW = $clog2(MAX_ROWS);
  localparam int NW = $clog2(MAX_ROWS + 1);

  row_t mem [MAX_ROWS];
  row_t rd_row_r;
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  row_t          wr_row;

  logic signed [DATA_W-1:0] e_r;
  logic [IW-1:0] l_r, u_r, mid;
  logic [IW:0]   sum_lu;
  row_t          l_row_r, u_row_r;

  logic [1:0]               res_status_r;
  logic signed [DATA_W-1:0] res_energy_r, res_low_r, res_high_r;
  logic [1:0]               out_status_r;
  logic signed [DATA_W-1:0] out_energy_r, out_low_r, out_high_r;

  logic signed [DATA_W:0] delta, dx, dy_lo, dy_hi;
  logic signed [DATA_W:0] y_lo, y_hi;
  logic [DATA_W-1:0]      dx_c, mag_lo, mag_hi, mdu_q;
  logic                   mdu_done;
  logic                   eq_mid, eq_u, lt_mid;

  // ---- row memory ----
  assign wr_addr = IW'(in_row_index);
  assign wr_en   = cmd.accept_wr && (32'(in_row_index) < 32'(MAX_ROWS));
  assign wr_row  = '{energy: in_energy_in, low: in_low_in, high: in_high_in};

  assign sum_lu = {1'b0, l_r} + {1'b0, u_r};
  assign mid    = sum_lu[IW:1];

  assign rd_en = cmd.rd_first || cmd.cap_l_rd_u || cmd.probe_rd;
  always_comb begin
    rd_addr = mid;
    if (cmd.rd_first) begin
      rd_addr = '0;
    end else if (cmd.cap_l_rd_u) begin
      rd_addr = IW'(n - NW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rd_row_r <= mem[rd_addr];
    end
  end

  // ---- search ----
  assign eq_mid = (e_r == rd_row_r.energy);
  assign eq_u   = (e_r == u_row_r.energy);
  assign lt_mid = (e_r < rd_row_r.energy);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l_r <= '0;
      u_r <= '0;
    end else begin
      if (cmd.accept_q) begin
        l_r <= '0;
      end
      if (cmd.cap_l_rd_u) begin
        u_r <= IW'(n - NW'(1));
      end
      if (cmd.u_to_l) begin
        u_r <= l_r;
      end
      if (cmd.cmp_upd) begin
        if (eq_mid) begin
          l_r <= mid;
          u_r <= mid;
        end else if (eq_u) begin
          l_r <= u_r;
        end else if (lt_mid) begin
          u_r <= mid;
        end else if (l_r != mid) begin
          l_r <= mid;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept_q) begin
      e_r <= in_energy_in;
    end
    if (cmd.cap_l_rd_u) begin
      l_row_r <= rd_row_r;
    end
    if (cmd.cap_u) begin
      u_row_r <= rd_row_r;
    end
    if (cmd.u_to_l) begin
      u_row_r <= l_row_r;
    end
    if (cmd.cmp_upd) begin
      if (eq_mid) begin
        l_row_r <= rd_row_r;
        u_row_r <= rd_row_r;
      end else if (eq_u) begin
        l_row_r <= u_row_r;
      end else if (lt_mid) begin
        u_row_r <= rd_row_r;
      end else if (l_r != mid) begin
        l_row_r <= rd_row_r;
      end
    end
  end

  // ---- interpolation ----
  assign delta = sx(u_row_r.energy) - sx(l_row_r.energy);
  assign dx    = sx(e_r) - sx(l_row_r.energy);

  always_comb begin
    dx_c = dx[DATA_W-1:0];
    if (dx < 0) begin
      dx_c = '0;
    end else if (dx > delta) begin
      dx_c = delta[DATA_W-1:0];
    end
  end

  assign dy_lo  = sx(u_row_r.low) - sx(l_row_r.low);
  assign dy_hi  = sx(u_row_r.high) - sx(l_row_r.high);
  assign mag_lo = dy_lo[DATA_W] ? DATA_W'(-dy_lo) : dy_lo[DATA_W-1:0];
  assign mag_hi = dy_hi[DATA_W] ? DATA_W'(-dy_hi) : dy_hi[DATA_W-1:0];

  ilt_mdu u_mdu (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.start_mdu),
    .a     (cmd.mdu_hi ? mag_hi : mag_lo),
    .b     (dx_c),
    .d     (delta[DATA_W-1:0]),
    .done  (mdu_done),
    .q     (mdu_q)
  );

  assign y_lo = dy_lo[DATA_W] ? sx(l_row_r.low) - $signed({1'b0, mdu_q})
                              : sx(l_row_r.low) + $signed({1'b0, mdu_q});
  assign y_hi = dy_hi[DATA_W] ? sx(l_row_r.high) - $signed({1'b0, mdu_q})
                              : sx(l_row_r.high) + $signed({1'b0, mdu_q});

  // ---- result staging and output register ----
  always_ff @(posedge clk) begin
    if (cmd.set_oor) begin
      res_status_r <= ST_RANGE;
      res_energy_r <= e_r;
      res_low_r    <= '0;
      res_high_r   <= '0;
    end
    if (cmd.set_direct) begin
      res_status_r <= ST_VALID;
      res_energy_r <= l_row_r.energy;
      res_low_r    <= l_row_r.low;
      res_high_r   <= l_row_r.high;
    end
    if (cmd.cap_lo) begin
      res_low_r <= y_lo[DATA_W-1:0];
    end
    if (cmd.cap_hi) begin
      res_high_r   <= y_hi[DATA_W-1:0];
      res_energy_r <= e_r;
      res_status_r <= ($signed(y_hi[DATA_W-1:0]) < res_low_r) ? ST_INVERTED : ST_VALID;
    end
    if (cmd.load_out) begin
      out_status_r <= res_status_r;
      out_energy_r <= res_energy_r;
      out_low_r    <= res_low_r;
      out_high_r   <= res_high_r;
    end
  end

  assign out_status     = out_status_r;
  assign out_energy_out = out_energy_r;
  assign out_low_out    = out_low_r;
  assign out_high_out   = out_high_r;

  // ---- status ----
  assign sts.op_query  = (in_op == OP_QUERY);
  assign sts.n_zero    = (n == '0);
  assign sts.out_range = (e_r < l_row_r.energy) || (e_r > rd_row_r.energy);
  assign sts.l_lt_u    = (l_r < u_r);
  assign sts.e_eq_l    = (e_r == l_row_r.energy);
  assign sts.cmp_break = !eq_mid && !eq_u && !lt_mid && (l_r == mid);
  assign sts.do_interp = (l_r != u_r) && (delta > 0);
  assign sts.mdu_done  = mdu_done;

  `ASSERT_IMPLIES(a_bounds_ordered, 1'b1, l_r <= u_r, "search bounds crossed")
  `ASSERT_IMPLIES(a_div_by_positive, cmd.start_mdu, delta > 0,
                  "interpolation started with non-positive energy gap")

endmodule

@@ sv/ilt_ctrl.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ilt_ctrl
  import ilt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && sts.op_query) begin
          state_nxt = S_RD_LO;
        end
      end
      S_RD_LO: begin
        state_nxt = sts.n_zero ? S_OUT : S_RD_HI;
      end
      S_RD_HI: begin
        state_nxt = S_RANGE;
      end
      S_RANGE: begin
        state_nxt = sts.out_range ? S_OUT : S_PROBE;
      end
      S_PROBE: begin
        if (!sts.l_lt_u || sts.e_eq_l) begin
          state_nxt = S_SEL;
        end else begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        state_nxt = sts.cmp_break ? S_SEL : S_PROBE;
      end
      S_SEL: begin
        state_nxt = sts.do_interp ? S_DIV_LO : S_OUT;
      end
      S_DIV_LO: begin
        if (sts.mdu_done) begin
          state_nxt = S_DIV_HI;
        end
      end
      S_DIV_HI: begin
        if (sts.mdu_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept_q  = sts.op_query;
          cmd.accept_wr = !sts.op_query;
        end
      end
      S_RD_LO: begin
        cmd.set_oor  = sts.n_zero;
        cmd.rd_first = !sts.n_zero;
      end
      S_RD_HI: begin
        cmd.cap_l_rd_u = 1'b1;
      end
      S_RANGE: begin
        cmd.cap_u   = 1'b1;
        cmd.set_oor = sts.out_range;
      end
      S_PROBE: begin
        if (sts.l_lt_u) begin
          cmd.u_to_l   = sts.e_eq_l;
          cmd.probe_rd = !sts.e_eq_l;
        end
      end
      S_CMP: begin
        cmd.cmp_upd = 1'b1;
      end
      S_SEL: begin
        cmd.start_mdu  = sts.do_interp;
        cmd.set_direct = !sts.do_interp;
      end
      S_DIV_LO: begin
        if (sts.mdu_done) begin
          cmd.cap_lo    = 1'b1;
          cmd.start_mdu = 1'b1;
          cmd.mdu_hi    = 1'b1;
        end
      end
      S_DIV_HI: begin
        cmd.cap_hi = sts.mdu_done;
      end
      S_OUT: begin
        cmd.load_out = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  assign out_valid_nxt = cmd.load_out || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `ASSERT_NEXT(a_load_shows_result, cmd.load_out, out_valid_r,
               "loaded result not presented")
  `ASSERT_IMPLIES(a_done_only_in_div, sts.mdu_done,
                  state_r == S_DIV_LO || state_r == S_DIV_HI,
                  "divider finished outside an interpolation state")

endmodule

@@ sv/interpolated_limit_table_lookup_unit.sv @@
`timescale 1ns / 1ps

// Limit table with linear interpolation. Write items (op 0) store one row
// (energy, low, high) in a row memory with one write and one read port
// and produce no result; rows must be written before a query can reach
// them, and the table must be kept sorted by ascending energy. Query items
// (op 1) read and range-check the first and last rows, then run a binary
// search (one memory read per probe, up to 9 probes for a full 256-row
// table), then a select step. When the energy falls strictly between two
// rows the low and high limits go one after the other through a shared
// multiply/divide unit (a 32x32 multiply, then one quotient bit per
// cycle); this unit sets the query time. The input stays stalled until a
// query is finished, also while the previous result still waits on the
// output. Only one query is in flight; the output register lets the next
// item be accepted while a result is still waiting. row_count sits at
// byte address 0 of the register port; values above MAX_ROWS are treated
// as MAX_ROWS.
module interpolated_limit_table_lookup_unit
  import ilt_pkg::*;
#(
  parameter int MAX_ROWS = 256
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // register port
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [2:0]               cfg_paddr,
  input  logic [31:0]              cfg_pwdata,
  output logic [31:0]              cfg_prdata,
  output logic                     cfg_pready,
  // item channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_op,
  input  logic [7:0]               in_row_index,
  input  logic signed [DATA_W-1:0] in_energy_in,
  input  logic signed [DATA_W-1:0] in_low_in,
  input  logic signed [DATA_W-1:0] in_high_in,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               out_status,
  output logic signed [DATA_W-1:0] out_energy_out,
  output logic signed [DATA_W-1:0] out_low_out,
  output logic signed [DATA_W-1:0] out_high_out
);

  localparam int NW = $clog2(MAX_ROWS + 1);

  logic [8:0]    row_count_r, row_count_nxt;
  logic          reg_wr;
  logic [NW-1:0] n;
  cmd_t          cmd;
  sts_t          sts;

  assign cfg_pready = 1'b1;
  assign reg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  assign row_count_nxt = (reg_wr && (cfg_paddr[2] == REG_ROW_COUNT))
                         ? cfg_pwdata[8:0] : row_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= '0;
    end else begin
      row_count_r <= row_count_nxt;
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_ROW_COUNT) ? 32'(row_count_r) : '0;

  assign n = (32'(row_count_r) > 32'(MAX_ROWS)) ? NW'(MAX_ROWS) : NW'(row_count_r);

  ilt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ilt_dp #(
    .MAX_ROWS (MAX_ROWS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .n              (n),
    .in_op          (in_op),
    .in_row_index   (in_row_index),
    .in_energy_in   (in_energy_in),
    .in_low_in      (in_low_in),
    .in_high_in     (in_high_in),
    .out_status     (out_status),
    .out_energy_out (out_energy_out),
    .out_low_out    (out_low_out),
    .out_high_out   (out_high_out)
  );

endmodule

@@ bench/interpolated_limit_table_lookup_unit_tb.sv @@
`timescale 1ns / 1ps

module interpolated_limit_table_lookup_unit_tb
  import ilt_pkg::*;
();

  localparam int TABLE_ROWS = 256;
  localparam int DRAIN_CYCLES = 150;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic signed [DATA_W-1:0] MIN_Q = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] MAX_Q = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] ONE = 32'sh0001_0000;
  localparam longint E_MIN = -64'sd2147483648;
  localparam longint E_MAX = 64'sd2147483647;

  typedef struct {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] energy;
    logic signed [DATA_W-1:0] low;
    logic signed [DATA_W-1:0] high;
  } limit_result_t;

  class limit_lookup_checker;
    logic signed [DATA_W-1:0] row_e[TABLE_ROWS];
    logic signed [DATA_W-1:0] row_lo[TABLE_ROWS];
    logic signed [DATA_W-1:0] row_hi[TABLE_ROWS];
    logic [8:0] row_count;
    limit_result_t pending_limits[$];
    int mismatches;

    function new();
      foreach (row_e[i]) begin
        row_e[i] = '0;
        row_lo[i] = '0;
        row_hi[i] = '0;
      end
      row_count = '0;
      mismatches = 0;
    endfunction

    function int active_rows();
      return (row_count > TABLE_ROWS) ? TABLE_ROWS : int'(row_count);
    endfunction

    // correction term truncated toward zero, magnitude taken before the divide
    function longint interp_limit(longint y0, longint y1, longint dx, longint span);
      longint dy;
      logic [127:0] mag;
      logic [127:0] q;
      dy = y1 - y0;
      mag = (dy < 0) ? 128'(-dy) : 128'(dy);
      q = (mag * 128'(dx)) / 128'(span);
      return (dy < 0) ? y0 - longint'(q[63:0]) : y0 + longint'(q[63:0]);
    endfunction

    function limit_result_t lookup_limits(logic signed [DATA_W-1:0] e);
      limit_result_t r;
      int n;
      int l;
      int u;
      int mid;
      longint span;
      longint dx;
      longint lo_v;
      longint hi_v;
      n = active_rows();
      r.status = ST_VALID;
      if (n == 0 || e < row_e[0] || e > row_e[n-1]) begin
        r.status = ST_RANGE;
        r.energy = e;
        r.low = '0;
        r.high = '0;
        return r;
      end
      l = 0;
      u = n - 1;
      while (l < u) begin
        mid = (l + u) / 2;
        if (e == row_e[l]) begin
          u = l;
        end else if (e == row_e[mid]) begin
          l = mid;
          u = mid;
        end else if (e == row_e[u]) begin
          l = u;
        end else if (e < row_e[mid]) begin
          u = mid;
        end else begin
          if (l == mid) break;
          l = mid;
        end
      end
      span = longint'(row_e[u]) - longint'(row_e[l]);
      if (u != l && span > 0) begin
        // offset clamped so an unsorted table still lands between the rows
        dx = longint'(e) - longint'(row_e[l]);
        if (dx < 0) dx = 0;
        if (dx > span) dx = span;
        lo_v = interp_limit(row_lo[l], row_lo[u], dx, span);
        hi_v = interp_limit(row_hi[l], row_hi[u], dx, span);
        r.energy = e;
        r.low = lo_v[31:0];
        r.high = hi_v[31:0];
        if (hi_v < lo_v) r.status = ST_INVERTED;
      end else begin
        r.energy = row_e[l];
        r.low = row_lo[l];
        r.high = row_hi[l];
      end
      return r;
    endfunction

    function void note_item(logic op, logic [7:0] idx, logic signed [DATA_W-1:0] e,
                            logic signed [DATA_W-1:0] lo, logic signed [DATA_W-1:0] hi);
      if (op == OP_WRITE) begin
        row_e[idx] = e;
        row_lo[idx] = lo;
        row_hi[idx] = hi;
      end else begin
        pending_limits.push_back(lookup_limits(e));
      end
    endfunction

    task report_mismatch(string msg);
      if (mismatches < 50) $display("ERROR @%0t: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(logic [1:0] st, logic signed [DATA_W-1:0] e,
                      logic signed [DATA_W-1:0] lo, logic signed [DATA_W-1:0] hi);
      limit_result_t want;
      if (pending_limits.size() == 0) begin
        report_mismatch($sformatf("result with no query pending: status %0d energy %0d",
                                  st, e));
        return;
      end
      want = pending_limits.pop_front();
      if (st !== want.status)
        report_mismatch($sformatf("status %0d, expected %0d", st, want.status));
      if (e !== want.energy)
        report_mismatch($sformatf("energy_out %0d, expected %0d", e, want.energy));
      if (lo !== want.low)
        report_mismatch($sformatf("low_out %0d, expected %0d", lo, want.low));
      if (hi !== want.high)
        report_mismatch($sformatf("high_out %0d, expected %0d", hi, want.high));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_op = 1'b0;
  logic [7:0] in_row_index = '0;
  logic signed [DATA_W-1:0] in_energy_in = '0;
  logic signed [DATA_W-1:0] in_low_in = '0;
  logic signed [DATA_W-1:0] in_high_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status;
  logic signed [DATA_W-1:0] out_energy_out;
  logic signed [DATA_W-1:0] out_low_out;
  logic signed [DATA_W-1:0] out_high_out;

  bit quiet = 1'b0;
  int stall_left = 0;
  int cycle_count = 0;
  limit_lookup_checker sb = new();

  interpolated_limit_table_lookup_unit uut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** interpolated_limit_table_lookup_unit: FAILED **");
      $finish;
    end
  end

  // result-side backpressure in short bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!quiet && rst_n && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_status, out_energy_out, out_low_out, out_high_out);
  end

  task automatic send_item(input logic op, input logic [7:0] idx,
                           input logic signed [DATA_W-1:0] e,
                           input logic signed [DATA_W-1:0] lo,
                           input logic signed [DATA_W-1:0] hi);
    int gap;
    gap = (!quiet && $urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_op <= op;
    in_row_index <= idx;
    in_energy_in <= e;
    in_low_in <= lo;
    in_high_in <= hi;
    do @(posedge clk); while (in_stall);
    sb.note_item(op, idx, e, lo, hi);
  endtask

  task automatic query_at(input logic signed [DATA_W-1:0] e);
    send_item(OP_QUERY, 8'($urandom), e, $urandom, $urandom);
  endtask

  // only touched with the block idle; writes leave no result, so wait out the pipe
  task automatic set_row_count(input int n);
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_limits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {REG_ROW_COUNT, 2'b00};
    cfg_pwdata <= 32'(n);
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.row_count = n[8:0];
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic random_limits(output logic signed [DATA_W-1:0] lo,
                               output logic signed [DATA_W-1:0] hi);
    if ($urandom_range(0, 3) == 0) begin
      lo = $urandom;
      hi = $urandom;
    end else begin
      lo = $signed($urandom) >>> 1;
      hi = lo + $urandom_range(0, 32'h3FFF_FFFF);
    end
  endtask

  // ascending energies: wide spread, medium steps, or tight steps with repeats
  task automatic load_sorted_table(input int n);
    int unsigned step_max;
    int style;
    bit pin_ends;
    longint acc;
    logic signed [DATA_W-1:0] e;
    logic signed [DATA_W-1:0] lo;
    logic signed [DATA_W-1:0] hi;
    style = $urandom_range(0, 2);
    pin_ends = (n >= 2) && ($urandom_range(0, 3) == 0);
    case (style)
      0: begin
        step_max = 32'hFFFF_FFFF / (n + 1);
        acc = E_MIN + longint'($urandom_range(0, step_max));
      end
      1: begin
        step_max = 32'd1 << 20;
        acc = longint'($signed($urandom) >>> 2);
      end
      default: begin
        step_max = 2;
        acc = longint'($signed($urandom) >>> 10);
      end
    endcase
    for (int i = 0; i < n; i++) begin
      if (i > 0) begin
        if (style == 2) acc += longint'($urandom_range(0, 2)) * 65536;
        else acc += longint'($urandom_range(0, step_max));
      end
      if (acc > E_MAX) acc = E_MAX;
      e = acc[31:0];
      if (pin_ends && i == 0) e = MIN_Q;
      if (pin_ends && i == n - 1) e = MAX_Q;
      random_limits(lo, hi);
      send_item(OP_WRITE, i[7:0], e, lo, hi);
    end
  endtask

  function automatic logic signed [DATA_W-1:0] pick_query_energy();
    int n;
    int i;
    int r;
    longint a;
    longint b;
    longint v;
    n = sb.active_rows();
    if (n == 0) return $urandom;
    r = $urandom_range(0, 99);
    a = sb.row_e[0];
    b = sb.row_e[n-1];
    if (r < 20) return sb.row_e[$urandom_range(0, n - 1)];
    if (r < 70 && n >= 2) begin
      i = $urandom_range(0, n - 2);
      a = sb.row_e[i];
      b = sb.row_e[i+1];
      v = (b <= a) ? a : a + longint'($urandom) % (b - a + 1);
      return v[31:0];
    end
    if (r < 85) begin
      if ($urandom_range(0, 1) && a > E_MIN) v = a - 1 - longint'($urandom) % (a - E_MIN);
      else if (b < E_MAX) v = b + 1 + longint'($urandom) % (E_MAX - b);
      else v = longint'($signed($urandom));
      return v[31:0];
    end
    return $urandom;
  endfunction

  // unused rows, order-keeping rewrites, or anything at all
  task automatic random_write();
    int n;
    int r;
    int idx;
    longint a;
    longint b;
    longint v;
    logic signed [DATA_W-1:0] lo;
    logic signed [DATA_W-1:0] hi;
    n = sb.active_rows();
    r = $urandom_range(0, 99);
    random_limits(lo, hi);
    if (r < 50 && n < TABLE_ROWS) begin
      idx = $urandom_range(n, TABLE_ROWS - 1);
      send_item(OP_WRITE, idx[7:0], $urandom, lo, hi);
    end else if (r < 85 && n >= 1) begin
      idx = $urandom_range(0, n - 1);
      a = (idx > 0) ? longint'(sb.row_e[idx-1]) : E_MIN;
      b = (idx < n - 1) ? longint'(sb.row_e[idx+1]) : E_MAX;
      v = (b >= a) ? a + longint'($urandom) % (b - a + 1) : longint'(sb.row_e[idx]);
      send_item(OP_WRITE, idx[7:0], v[31:0], lo, hi);
    end else begin
      send_item(OP_WRITE, 8'($urandom), $urandom, $urandom, $urandom);
    end
  endtask

  task automatic run_phase(input int n, input int items);
    set_row_count(n);
    load_sorted_table(n);
    for (int k = 0; k < items; k++) begin
      if ($urandom_range(0, 6) == 0) random_write();
      else query_at(pick_query_energy());
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty table after reset
    query_at(0);
    query_at(MIN_Q);
    // full-range rows: inverted stored row, repeated energy, inverting span
    send_item(OP_WRITE, 8'd0, MIN_Q, MIN_Q, MAX_Q);
    send_item(OP_WRITE, 8'd1, 0, MAX_Q, MIN_Q);
    send_item(OP_WRITE, 8'd2, 0, 10 * ONE, 20 * ONE);
    send_item(OP_WRITE, 8'd3, MAX_Q, -5 * ONE, -6 * ONE);
    set_row_count(4);
    query_at(MIN_Q);
    query_at(MAX_Q);
    query_at(-1);
    query_at(0);
    query_at(32'sh4000_0000);
    query_at(MAX_Q - 1);
    set_row_count(2);
    query_at(1);
    query_at(0);
    // row 2 now out of order
    send_item(OP_WRITE, 8'd2, -100 * ONE, ONE, 2 * ONE);
    set_row_count(4);
    query_at(50 * ONE);
    query_at(-50 * ONE);
    set_row_count(1);
    query_at(MIN_Q);
    query_at(MIN_Q + 1);

    run_phase(TABLE_ROWS, 60);
    run_phase(2, 50);
    run_phase($urandom_range(3, 12), 60);
    run_phase(1, 30);
    run_phase(0, 10);
    run_phase($urandom_range(13, 40), 70);
    run_phase($urandom_range(41, 120), 80);
    quiet = 1'b1;
    run_phase($urandom_range(3, 8), 60);

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_limits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("** interpolated_limit_table_lookup_unit: PASSED **");
    end else begin
      $display("** interpolated_limit_table_lookup_unit: FAILED **");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/ilt_pkg.sv
sv/ilt_mdu.sv
sv/ilt_dp.sv
sv/ilt_ctrl.sv
sv/interpolated_limit_table_lookup_unit.sv
bench/interpolated_limit_table_lookup_unit_tb.sv
